// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clock edge, held off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lus_pkg.sv
// ----------------------------------------------------------------------------
// lus_pkg
// Shared constants for the longest unique substring core.
// ----------------------------------------------------------------------------
package lus_pkg;

  localparam int BYTE_W            = 8;
  localparam int SYMBOL_COUNT      = 256;
  localparam int SYM_W             = $clog2(SYMBOL_COUNT);
  localparam int MAX_STRING_LENGTH = 65536;
  localparam int POS_W_DEFAULT     = $clog2(MAX_STRING_LENGTH);

endpackage

// File: rtl/core/lus_pos_mem.sv
// ----------------------------------------------------------------------------
// lus_pos_mem
// Last-position table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lus_pos_mem #(
  parameter int DEPTH = lus_pkg::SYMBOL_COUNT,
  parameter int WIDTH = lus_pkg::POS_W_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/longest_unique_substring_core.sv
// ----------------------------------------------------------------------------
// longest_unique_substring_core
// Streams a string one byte per beat and reports the earliest longest run of
// distinct bytes, its start and an overflow flag on the last byte.
//
//   channel | direction | payload                                  | flow
//   in_     | input     | byte_value, end_of_string                | valid/stall
//   out_    | output    | longest_length, longest_start, overflow  | valid/stall
//
// One byte per cycle unless the input stalls: the table read is issued on the
// input beat, the read-modify-write completes in stage 1, and a bypass covers
// back to back bytes of the same value.
// Result is written to the output register when stage 1 retires the last byte.
// No clearing pass after reset; seen marks are flip-flops cleared at once.
// Input stalls only when a result waits in the output register and the last
// byte of the next string is ready to report.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_unique_substring_core #(
  parameter int MAX_STRING_LENGTH = lus_pkg::MAX_STRING_LENGTH,
  localparam int LEN_W = $clog2(MAX_STRING_LENGTH + 1),
  localparam int POS_W = $clog2(MAX_STRING_LENGTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lus_pkg::BYTE_W-1:0] in_byte_value,
  input  logic                      in_end_of_string,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LEN_W-1:0]          out_longest_length,
  output logic [POS_W-1:0]          out_longest_start,
  output logic                      out_overflow
);

  localparam int SYM_W = lus_pkg::SYM_W;

  // stage 1 control and payload
  logic                 s1_valid_r, s1_valid_nxt;
  logic [SYM_W-1:0]     s1_sym_r;
  logic                 s1_eos_r;
  logic                 s1_fwd_r;
  logic [POS_W-1:0]     s1_fwd_pos_r;

  // string state
  logic [lus_pkg::SYMBOL_COUNT-1:0] seen_r, seen_nxt;
  logic [LEN_W-1:0]     next_pos_r, next_pos_nxt;
  logic [POS_W-1:0]     win_start_r, win_start_nxt;
  logic [LEN_W-1:0]     best_len_r, best_len_nxt;
  logic [POS_W-1:0]     best_start_r, best_start_nxt;
  logic                 ovf_r, ovf_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]     out_len_r;
  logic [POS_W-1:0]     out_start_r;
  logic                 out_ovf_r;

  logic                 in_fire;
  logic                 s1_adv;
  logic                 s1_fire;
  logic                 s1_take;
  logic [POS_W-1:0]     mem_rd_data;
  logic [POS_W-1:0]     last_pos;
  logic [POS_W-1:0]     cur_pos;
  logic [POS_W-1:0]     ws_new;
  logic [LEN_W-1:0]     cur_len;
  logic                 hit;

  // a non-final byte always moves on; a final byte needs room in the output
  assign s1_adv   = !s1_eos_r || !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  assign s1_take  = next_pos_r < LEN_W'(MAX_STRING_LENGTH);
  assign cur_pos  = next_pos_r[POS_W-1:0];
  assign last_pos = s1_fwd_r ? s1_fwd_pos_r : mem_rd_data;
  assign hit      = seen_r[s1_sym_r] && (last_pos >= win_start_r);
  assign ws_new   = hit ? last_pos + POS_W'(1) : win_start_r;
  assign cur_len  = next_pos_r - LEN_W'(ws_new) + LEN_W'(1);

  lus_pos_mem #(
    .DEPTH (lus_pkg::SYMBOL_COUNT),
    .WIDTH (POS_W)
  ) u_pos_mem (
    .clk       (clk),
    .wr_en     (s1_fire && s1_take),
    .wr_addr   (s1_sym_r),
    .wr_data   (cur_pos),
    .rd_en     (in_fire),
    .rd_addr   (in_byte_value[SYM_W-1:0]),
    .rd_data_r (mem_rd_data)
  );

  always_comb begin
    s1_valid_nxt   = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    seen_nxt       = seen_r;
    next_pos_nxt   = next_pos_r;
    win_start_nxt  = win_start_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (s1_fire) begin
      if (s1_take) begin
        seen_nxt[s1_sym_r] = 1'b1;
        next_pos_nxt       = next_pos_r + LEN_W'(1);
        win_start_nxt      = ws_new;
        if (cur_len > best_len_r) begin
          best_len_nxt   = cur_len;
          best_start_nxt = ws_new;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
      if (s1_eos_r) begin
        out_valid_nxt  = 1'b1;
        seen_nxt       = '0;
        next_pos_nxt   = '0;
        win_start_nxt  = '0;
        best_len_nxt   = '0;
        best_start_nxt = '0;
        ovf_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      seen_r       <= '0;
      next_pos_r   <= '0;
      win_start_r  <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      seen_r       <= seen_nxt;
      next_pos_r   <= next_pos_nxt;
      win_start_r  <= win_start_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload: capture the beat and the bypass for a same-byte write in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sym_r     <= in_byte_value[SYM_W-1:0];
      s1_eos_r     <= in_end_of_string;
      s1_fwd_r     <= s1_fire && s1_take && (s1_sym_r == in_byte_value[SYM_W-1:0]);
      s1_fwd_pos_r <= cur_pos;
    end
    if (s1_fire && s1_eos_r) begin
      if (s1_take && (cur_len > best_len_r)) begin
        out_len_r   <= cur_len;
        out_start_r <= ws_new;
      end else begin
        out_len_r   <= best_len_r;
        out_start_r <= best_start_r;
      end
      out_ovf_r <= ovf_r || !s1_take;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_longest_length = out_len_r;
  assign out_longest_start  = out_start_r;
  assign out_overflow       = out_ovf_r;

  `ASSERT_IMPL(a_accept_needs_room, clk, rst_n, in_fire, !s1_valid_r || s1_adv, "beat accepted while stage 1 is held")
  `ASSERT_IMPL(a_result_nonempty, clk, rst_n, out_valid_r, out_len_r != '0, "result length is zero")
  `ASSERT_CLK(a_best_le_pos, clk, rst_n, best_len_r <= next_pos_r, "best length exceeds bytes taken")
  `ASSERT_CLK(a_win_le_pos, clk, rst_n, LEN_W'(win_start_r) <= next_pos_r, "window start past position")
  `ASSERT_IMPL(a_clear_after_eos, clk, rst_n, s1_fire && s1_eos_r, ##1 (next_pos_r == '0 && seen_r == '0), "string state not cleared after last byte")

endmodule
